>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the sorted key table
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define SKT_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted key table check failed");

// consequence must hold in the cycle after the antecedent
`define SKT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key table sequence check failed");

`endif

>>> sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared constants, codes and control types of the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skt_pkg;

    localparam int DEPTH   = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 64;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;
    localparam int TOTAL_W = 6;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_SEARCH = 2'd2,
        ACT_LIST   = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4,
        ST_EMPTY     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_EXEC,
        S_LIST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic req_ready;
        logic compare;
        logic exec;
        logic list_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_valid;
        logic rsp_free;
        logic is_list;
        logic empty;
        logic list_last;
    } dp_status_t;

endpackage

>>> sv/skt_if.sv
// ----------------------------------------------------------------------------
// skt_if
// request and response channels of the sorted key table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface skt_req_if;
    logic                             valid;
    logic                             ready;
    logic [skt_pkg::ACT_W-1:0]        action;
    logic signed [skt_pkg::KEY_W-1:0] key;
    logic [skt_pkg::PAY_W-1:0]        payload;

    modport source (output valid, output action, output key, output payload, input ready);
    modport sink   (input valid, input action, input key, input payload, output ready);
endinterface

interface skt_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [skt_pkg::STAT_W-1:0]       status;
    logic signed [skt_pkg::KEY_W-1:0] out_key;
    logic [skt_pkg::PAY_W-1:0]        out_payload;
    logic [skt_pkg::TOTAL_W-1:0]      entry_total;
    logic                             last;

    modport source (output valid, output status, output out_key, output out_payload,
                    output entry_total, output last, input ready);
    modport sink   (input valid, input status, input out_key, input out_payload,
                    input entry_total, input last, output ready);
endinterface

>>> sv/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// operation sequencer: accept, compare, execute, list walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module skt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  skt_pkg::dp_status_t sts,
    output skt_pkg::cmd_t       cmd
);

    skt_pkg::state_t state_reg;
    skt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = skt_pkg::S_COMPARE;
                end
            end
            skt_pkg::S_COMPARE:
            begin
                state_next = skt_pkg::S_EXEC;
            end
            skt_pkg::S_EXEC:
            begin
                if (sts.rsp_free)
                begin
                    if (sts.is_list && !sts.empty)
                    begin
                        state_next = skt_pkg::S_LIST;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_IDLE;
                    end
                end
            end
            skt_pkg::S_LIST:
            begin
                if (sts.rsp_free && sts.list_last)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                cmd.req_ready = 1'b1;
            end
            skt_pkg::S_COMPARE:
            begin
                cmd.compare = 1'b1;
            end
            skt_pkg::S_EXEC:
            begin
                cmd.exec = sts.rsp_free;
            end
            skt_pkg::S_LIST:
            begin
                cmd.list_step = sts.rsp_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/skt_datapath.sv
// ----------------------------------------------------------------------------
// skt_datapath
// record cells, parallel key compare, shift insert and delete, output beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skt_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    skt_req_if.sink              req,
    skt_rsp_if.source            rsp,
    input  skt_pkg::cmd_t        cmd,
    output skt_pkg::dp_status_t  sts
);

    localparam int DEPTH   = skt_pkg::DEPTH;
    localparam int IDX_W   = skt_pkg::IDX_W;
    localparam int CNT_W   = skt_pkg::CNT_W;
    localparam int KEY_W   = skt_pkg::KEY_W;
    localparam int PAY_W   = skt_pkg::PAY_W;
    localparam int TOTAL_W = skt_pkg::TOTAL_W;

    // latched request
    skt_pkg::action_t         act_reg;
    logic signed [KEY_W-1:0]  key_in_reg;
    logic [PAY_W-1:0]         pay_in_reg;

    // record cells
    logic signed [KEY_W-1:0]  key_cell_reg  [DEPTH];
    logic signed [KEY_W-1:0]  key_cell_next [DEPTH];
    logic [PAY_W-1:0]         pay_cell_reg  [DEPTH];
    logic [PAY_W-1:0]         pay_cell_next [DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;

    // compare results
    logic [DEPTH-1:0]         eq_vec;
    logic [DEPTH-1:0]         lt_vec;
    logic [IDX_W-1:0]         hit_idx_c;
    logic [CNT_W-1:0]         pos_c;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    logic [CNT_W-1:0]         pos_reg;

    // list walk
    logic [IDX_W-1:0]         cursor_reg;

    // read port
    logic [IDX_W-1:0]         rd_idx;
    logic signed [KEY_W-1:0]  rd_key;
    logic [PAY_W-1:0]         rd_pay;

    logic                     ins_ok;
    logic                     del_ok;
    logic                     do_ins;
    logic                     do_del;
    logic                     is_empty;

    // output beat
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    skt_pkg::status_t         status_reg;
    skt_pkg::status_t         status_next;
    logic signed [KEY_W-1:0]  out_key_reg;
    logic signed [KEY_W-1:0]  out_key_next;
    logic [PAY_W-1:0]         out_pay_reg;
    logic [PAY_W-1:0]         out_pay_next;
    logic [TOTAL_W-1:0]       total_reg;
    logic [TOTAL_W-1:0]       total_next;
    logic                     last_reg;
    logic                     last_next;

    assign req.ready = cmd.req_ready;

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            act_reg    <= skt_pkg::action_t'(req.action);
            key_in_reg <= req.key;
            pay_in_reg <= req.payload;
        end
    end

    // parallel compare against every live cell
    always_comb
    begin
        hit_idx_c = '0;
        pos_c     = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            eq_vec[i] = (CNT_W'(i) < count_reg) && (key_cell_reg[i] == key_in_reg);
            lt_vec[i] = (CNT_W'(i) < count_reg) && (key_cell_reg[i] < key_in_reg);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (eq_vec[i])
            begin
                hit_idx_c = hit_idx_c | IDX_W'(i);
            end
            if (lt_vec[i])
            begin
                pos_c = CNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            hit_reg     <= |eq_vec;
            hit_idx_reg <= hit_idx_c;
            pos_reg     <= pos_c;
        end
    end

    assign is_empty = (count_reg == '0);
    assign ins_ok   = (act_reg == skt_pkg::ACT_INSERT) && (key_in_reg != '0) && !hit_reg
                      && (count_reg < CNT_W'(DEPTH));
    assign del_ok   = (act_reg == skt_pkg::ACT_DELETE) && hit_reg;
    assign do_ins   = cmd.exec && ins_ok;
    assign do_del   = cmd.exec && del_ok;

    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // cell shifting: insert opens a gap at pos, delete closes the hit
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [KEY_W-1:0] up_key;
        logic [PAY_W-1:0]        up_pay;
        logic signed [KEY_W-1:0] dn_key;
        logic [PAY_W-1:0]        dn_pay;

        if (g == 0)
        begin : g_first
            assign up_key = key_in_reg;
            assign up_pay = pay_in_reg;
        end
        else
        begin : g_rest
            assign up_key = key_cell_reg[g-1];
            assign up_pay = pay_cell_reg[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_top
            assign dn_key = key_cell_reg[g];
            assign dn_pay = pay_cell_reg[g];
        end
        else
        begin : g_below
            assign dn_key = key_cell_reg[g+1];
            assign dn_pay = pay_cell_reg[g+1];
        end

        always_comb
        begin
            key_cell_next[g] = key_cell_reg[g];
            pay_cell_next[g] = pay_cell_reg[g];
            if (do_ins && (CNT_W'(g) > pos_reg))
            begin
                key_cell_next[g] = up_key;
                pay_cell_next[g] = up_pay;
            end
            else if (do_ins && (CNT_W'(g) == pos_reg))
            begin
                key_cell_next[g] = key_in_reg;
                pay_cell_next[g] = pay_in_reg;
            end
            else if (do_del && (IDX_W'(g) >= hit_idx_reg))
            begin
                key_cell_next[g] = dn_key;
                pay_cell_next[g] = dn_pay;
            end
        end

        always_ff @(posedge clk)
        begin
            key_cell_reg[g] <= key_cell_next[g];
            pay_cell_reg[g] <= pay_cell_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            cursor_reg <= '0;
        end
        else if (cmd.list_step)
        begin
            cursor_reg <= cursor_reg + IDX_W'(1);
        end
    end

    // single read port, shared by search, delete and list
    assign rd_idx = cmd.list_step ? cursor_reg : hit_idx_reg;
    assign rd_key = key_cell_reg[rd_idx];
    assign rd_pay = pay_cell_reg[rd_idx];

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        out_key_next   = out_key_reg;
        out_pay_next   = out_pay_reg;
        total_next     = total_reg;
        last_next      = last_reg;
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.exec)
        begin
            rsp_valid_next = 1'b1;
            out_key_next   = key_in_reg;
            out_pay_next   = '0;
            total_next     = TOTAL_W'(count_next);
            last_next      = 1'b1;
            case (act_reg)
                skt_pkg::ACT_INSERT:
                begin
                    out_pay_next = pay_in_reg;
                    if (key_in_reg == '0)
                    begin
                        status_next = skt_pkg::ST_ZERO_KEY;
                    end
                    else if (hit_reg)
                    begin
                        status_next = skt_pkg::ST_DUPLICATE;
                    end
                    else if (!ins_ok)
                    begin
                        status_next = skt_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next = skt_pkg::ST_OK;
                    end
                end
                skt_pkg::ACT_DELETE,
                skt_pkg::ACT_SEARCH:
                begin
                    if (hit_reg)
                    begin
                        status_next  = skt_pkg::ST_OK;
                        out_pay_next = rd_pay;
                    end
                    else
                    begin
                        status_next = skt_pkg::ST_NOT_FOUND;
                    end
                end
                skt_pkg::ACT_LIST:
                begin
                    // a filled table is walked in the list state instead
                    status_next    = skt_pkg::ST_EMPTY;
                    out_key_next   = '0;
                    rsp_valid_next = is_empty;
                end
                default:
                begin
                    status_next = skt_pkg::ST_NOT_FOUND;
                end
            endcase
        end
        else if (cmd.list_step)
        begin
            rsp_valid_next = 1'b1;
            status_next    = skt_pkg::ST_OK;
            out_key_next   = rd_key;
            out_pay_next   = rd_pay;
            total_next     = TOTAL_W'(count_reg);
            last_next      = sts.list_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        out_key_reg <= out_key_next;
        out_pay_reg <= out_pay_next;
        total_reg   <= total_next;
        last_reg    <= last_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.out_key     = out_key_reg;
    assign rsp.out_payload = out_pay_reg;
    assign rsp.entry_total = total_reg;
    assign rsp.last        = last_reg;

    assign sts.req_valid = req.valid;
    assign sts.rsp_free  = !rsp_valid_reg || rsp.ready;
    assign sts.is_list   = (act_reg == skt_pkg::ACT_LIST);
    assign sts.empty     = is_empty;
    assign sts.list_last = ((CNT_W'(cursor_reg) + CNT_W'(1)) == count_reg);

    // keys are unique, so at most one live cell matches
    `SKT_ASSERT(a_single_hit, $onehot0(eq_vec))

    // a successful insert grows the table by exactly one record
    `SKT_ASSERT_NEXT(a_ins_count, do_ins, count_reg == $past(count_reg) + CNT_W'(1))

    // live cells stay in strictly ascending key order
    for (genvar g = 0; g < DEPTH - 1; g++)
    begin : g_order
        `SKT_ASSERT(a_sorted, (CNT_W'(g + 2) > count_reg) || (key_cell_reg[g] < key_cell_reg[g + 1]))
    end

endmodule

>>> sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// flow: a request beat is taken in idle and compared, then its result beat is
//   registered in execute, which waits while a beat is pending; a non-empty list
//   then sends one beat per cycle while the response is free, read through the
//   one-cell read port; a new request is taken only back in idle
// reset: rst_n clears the record count and the controller; cell contents are
//   left as they are and are never read before they are written
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_table (
    input  logic       clk,
    input  logic       rst_n,
    skt_req_if.sink    req,
    skt_rsp_if.source  rsp
);

    // command and status between the sequencer and the record datapath
    skt_pkg::cmd_t       cmd;
    skt_pkg::dp_status_t sts;

    // sequencer: idle -> compare -> execute, then a list walk when asked for
    skt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // datapath: record cells with parallel compare, shift on insert and
    // delete, and a response register so a finished beat can wait downstream
    skt_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
